/* src/sst_pkg.sv */
// Spindle speed snap table: shared types, codes and sizes.
// No dependencies; imported by every module of the block but sst_entry_ram.
`default_nettype none
package sst_pkg;

   localparam int MAX_ENTRIES = 16;
   localparam int SPEED_W     = 20;
   localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

   typedef logic [SPEED_W-1:0] speed_type;
   typedef logic [IDX_W-1:0]   idx_type;

   typedef enum logic [1:0] {
      FUNC_RANGE = 2'd0,
      FUNC_VALUE = 2'd1,
      FUNC_NORM  = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_HIT    = 3'd0,
      ST_SNAP   = 3'd1,
      ST_EMPTY  = 3'd2,
      ST_STORED = 3'd3,
      ST_DUP    = 3'd4,
      ST_FULL   = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE  = 2'd0,
      S_SCAN  = 2'd1,
      S_DRAIN = 2'd2,
      S_DONE  = 2'd3
   } state_type;

   typedef struct packed {
      logic      is_range;
      speed_type low;
      speed_type high;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // control from sequencer to scan datapath
   typedef struct packed {
      logic      clear;
      logic      rd_vld;
      logic      slot_valid;
      idx_type   slot;
      logic      norm;
      logic      is_range;
      speed_type lo;
      speed_type hi;
   } scan_cmd_type;

   // scan summary back to sequencer
   typedef struct packed {
      logic      busy;
      logic      dup;
      logic      free_found;
      idx_type   free_slot;
      logic      any;
      logic      hit;
      speed_type best_point;
   } scan_res_type;

endpackage
`default_nettype wire

/* src/sst_entry_ram.sv */
// Generic single-write, single-read synchronous RAM, registered read data.
// No package dependency; holds the entry table.
`default_nettype none
module sst_entry_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 41,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

/* src/sst_scan_eval.sv */
// Scan datapath: per-entry compare stage and accumulate stage.
// Depends on sst_pkg.
`default_nettype none
module sst_scan_eval (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire sst_pkg::scan_cmd_type cmd,
   input  wire sst_pkg::entry_type    rd_entry,
   output sst_pkg::scan_res_type      res
);
   import sst_pkg::*;

   logic      clash;
   logic      contains;
   speed_type point;
   speed_type delta;

   logic      s1_vld_ff,        s1_vld_in;
   logic      s1_slot_valid_ff;
   idx_type   s1_slot_ff;
   logic      s1_clash_ff;
   logic      s1_contains_ff;
   speed_type s1_point_ff;
   speed_type s1_delta_ff;

   logic      dup_ff,        dup_in;
   logic      free_found_ff, free_found_in;
   idx_type   free_slot_ff,  free_slot_in;
   logic      any_ff,        any_in;
   logic      hit_ff,        hit_in;
   speed_type best_point_ff, best_point_in;
   speed_type best_delta_ff, best_delta_in;
   logic      better;

   // stage 1: compare one entry against the request
   always_comb begin
      if (rd_entry.is_range == cmd.is_range) begin
         clash = (rd_entry.low == cmd.lo);
      end else if (rd_entry.is_range) begin
         clash = (cmd.lo >= rd_entry.low) && (cmd.lo <= rd_entry.high);
      end else begin
         clash = (rd_entry.low >= cmd.lo) && (rd_entry.low <= cmd.hi);
      end
      contains = (cmd.lo >= rd_entry.low) && (cmd.lo <= rd_entry.high);
      point    = (cmd.lo < rd_entry.low) ? rd_entry.low : rd_entry.high;
      delta    = (point > cmd.lo) ? (point - cmd.lo) : (cmd.lo - point);
   end

   assign s1_vld_in = cmd.rd_vld && !cmd.clear;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_slot_valid_ff <= cmd.slot_valid;
      s1_slot_ff       <= cmd.slot;
      s1_clash_ff      <= clash;
      s1_contains_ff   <= contains;
      s1_point_ff      <= point;
      s1_delta_ff      <= delta;
   end

   // stage 2: accumulate
   assign better = !any_ff || (s1_delta_ff < best_delta_ff) ||
                   ((s1_delta_ff == best_delta_ff) && (s1_point_ff < best_point_ff));

   always_comb begin
      dup_in        = dup_ff;
      free_found_in = free_found_ff;
      free_slot_in  = free_slot_ff;
      any_in        = any_ff;
      hit_in        = hit_ff;
      best_point_in = best_point_ff;
      best_delta_in = best_delta_ff;
      if (cmd.clear) begin
         dup_in        = 1'b0;
         free_found_in = 1'b0;
         any_in        = 1'b0;
         hit_in        = 1'b0;
      end else if (s1_vld_ff) begin
         if (s1_slot_valid_ff) begin
            any_in = 1'b1;
            if (s1_clash_ff) begin
               dup_in = 1'b1;
            end
            if (s1_contains_ff) begin
               hit_in = 1'b1;
            end
            if (better) begin
               best_point_in = s1_point_ff;
               best_delta_in = s1_delta_ff;
            end
         end else if (!free_found_ff) begin
            free_found_in = 1'b1;
            free_slot_in  = s1_slot_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dup_ff        <= 1'b0;
         free_found_ff <= 1'b0;
         any_ff        <= 1'b0;
         hit_ff        <= 1'b0;
      end else begin
         dup_ff        <= dup_in;
         free_found_ff <= free_found_in;
         any_ff        <= any_in;
         hit_ff        <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      free_slot_ff  <= free_slot_in;
      best_point_ff <= best_point_in;
      best_delta_ff <= best_delta_in;
   end

   always_comb begin
      res.busy       = s1_vld_ff;
      res.dup        = dup_ff;
      res.free_found = free_found_ff;
      res.free_slot  = free_slot_ff;
      res.any        = any_ff;
      res.hit        = hit_ff;
      res.best_point = best_point_ff;
   end

endmodule
`default_nettype wire

/* src/sst_ctrl.sv */
// Sequencer: request capture, entry scan, valid bits, table write, result register.
// Depends on sst_pkg.
`default_nettype none
module sst_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [1:0]            req_func,
   input  wire sst_pkg::speed_type    req_speed_a,
   input  wire sst_pkg::speed_type    req_speed_b,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output sst_pkg::speed_type         rsp_speed_out,
   output logic [2:0]                 rsp_status,
   output logic                       ram_rd_en,
   output sst_pkg::idx_type           ram_rd_addr,
   output logic                       ram_wr_en,
   output sst_pkg::idx_type           ram_wr_addr,
   output sst_pkg::entry_type         ram_wr_data,
   output sst_pkg::scan_cmd_type      cmd,
   input  wire sst_pkg::scan_res_type res
);
   import sst_pkg::*;

   localparam idx_type LAST_IDX = idx_type'(MAX_ENTRIES - 1);

   state_type  state_ff, state_in;
   idx_type    cnt_ff, cnt_in;
   func_type   func_ff;
   speed_type  lo_ff, hi_ff;
   logic       rd_vld_ff;
   logic       rd_slot_valid_ff;
   idx_type    rd_slot_ff;
   logic [MAX_ENTRIES-1:0] entry_valid_ff;

   logic       rsp_valid_ff, rsp_valid_in;
   speed_type  rsp_speed_ff, rsp_speed_in;
   status_type rsp_status_ff, rsp_status_in;

   logic       accept;
   logic       issue;
   logic       clear;
   logic       finish;
   logic       out_free;
   logic       store;
   speed_type  res_speed;
   status_type res_status;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = (func_type'(req_func) == FUNC_NONE) ? S_DONE : S_SCAN;
            end
         end
         S_SCAN: begin
            if (cnt_ff == LAST_IDX) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!rd_vld_ff && !res.busy) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      issue  = 1'b0;
      clear  = 1'b0;
      finish = 1'b0;
      case (state_ff)
         S_IDLE:  clear  = accept;
         S_SCAN:  issue  = 1'b1;
         S_DRAIN: issue  = 1'b0;
         S_DONE:  finish = out_free;
         default: issue  = 1'b0;
      endcase
   end

   // result decode
   always_comb begin
      res_speed  = '0;
      res_status = ST_DUP;
      store      = 1'b0;
      case (func_ff)
         FUNC_NORM: begin
            if (res.hit) begin
               res_speed  = lo_ff;
               res_status = ST_HIT;
            end else if (!res.any) begin
               res_speed  = lo_ff;
               res_status = ST_EMPTY;
            end else begin
               res_speed  = res.best_point;
               res_status = ST_SNAP;
            end
         end
         FUNC_RANGE, FUNC_VALUE: begin
            if (res.dup) begin
               res_status = ST_DUP;
            end else if (!res.free_found) begin
               res_status = ST_FULL;
            end else begin
               res_status = ST_STORED;
               store      = 1'b1;
            end
         end
         default: res_status = ST_DUP;
      endcase
   end

   assign cnt_in = clear ? '0 : (issue ? cnt_ff + idx_type'(1) : cnt_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         cnt_ff         <= '0;
         rd_vld_ff      <= 1'b0;
         entry_valid_ff <= '0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         rd_vld_ff <= issue;
         if (finish && store) begin
            entry_valid_ff[res.free_slot] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff <= func_type'(req_func);
         lo_ff   <= req_speed_a;
         hi_ff   <= (func_type'(req_func) == FUNC_VALUE) ? req_speed_a : req_speed_b;
      end
      rd_slot_valid_ff <= entry_valid_ff[cnt_ff];
      rd_slot_ff       <= cnt_ff;
   end

   assign rsp_valid_in  = finish || (rsp_valid_ff && rsp_stall);
   assign rsp_speed_in  = finish ? res_speed : rsp_speed_ff;
   assign rsp_status_in = finish ? res_status : rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_speed_ff  <= rsp_speed_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_speed_out = rsp_speed_ff;
   assign rsp_status    = rsp_status_ff;

   assign ram_rd_en            = issue;
   assign ram_rd_addr          = cnt_ff;
   assign ram_wr_en            = finish && store;
   assign ram_wr_addr          = res.free_slot;
   assign ram_wr_data.is_range = (func_ff == FUNC_RANGE);
   assign ram_wr_data.low      = lo_ff;
   assign ram_wr_data.high     = hi_ff;

   always_comb begin
      cmd.clear      = clear;
      cmd.rd_vld     = rd_vld_ff;
      cmd.slot_valid = rd_slot_valid_ff;
      cmd.slot       = rd_slot_ff;
      cmd.norm       = (func_ff == FUNC_NORM);
      cmd.is_range   = (func_ff == FUNC_RANGE);
      cmd.lo         = lo_ff;
      cmd.hi         = hi_ff;
   end

endmodule
`default_nettype wire

/* src/spindle_speed_snap_table_core.sv */
// Spindle speed snap table, top level.
// Depends on sst_pkg, sst_ctrl, sst_entry_ram, sst_scan_eval.
//
// One item is in flight at a time; req_stall is high from the transfer until the
// result is loaded. Inserts and normalise requests scan the entry memory through
// its single read port, one entry a cycle, and pass each entry through the
// two-stage compare pipeline before the result is loaded. An unused func code
// skips the scan. A waiting result does not block the next transfer. Valid bits
// clear at reset; no clearing pass.
`default_nettype none
module spindle_speed_snap_table_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_func,
   input  wire sst_pkg::speed_type req_speed_a,
   input  wire sst_pkg::speed_type req_speed_b,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output sst_pkg::speed_type      rsp_speed_out,
   output logic [2:0]              rsp_status
);
   import sst_pkg::*;

   logic         ram_rd_en;
   idx_type      ram_rd_addr;
   logic         ram_wr_en;
   idx_type      ram_wr_addr;
   entry_type    ram_wr_data;
   entry_type    ram_rd_data;
   scan_cmd_type cmd;
   scan_res_type res;

   sst_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_func      (req_func),
      .req_speed_a   (req_speed_a),
      .req_speed_b   (req_speed_b),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_speed_out (rsp_speed_out),
      .rsp_status    (rsp_status),
      .ram_rd_en     (ram_rd_en),
      .ram_rd_addr   (ram_rd_addr),
      .ram_wr_en     (ram_wr_en),
      .ram_wr_addr   (ram_wr_addr),
      .ram_wr_data   (ram_wr_data),
      .cmd           (cmd),
      .res           (res)
   );

   sst_entry_ram #(
      .DEPTH (MAX_ENTRIES),
      .WIDTH (ENTRY_W),
      .AW    (IDX_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   sst_scan_eval u_eval (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .rd_entry (ram_rd_data),
      .res      (res)
   );

endmodule
`default_nettype wire

/* src/sst_checker.sv */
// Port-level checks for the spindle speed snap table, bound to the top level.
// Depends on sst_pkg.
`default_nettype none
module sst_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_stall,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire sst_pkg::speed_type rsp_speed_out,
   input wire logic [2:0]         rsp_status
);
   import sst_pkg::*;

   a_reset_no_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid straight after reset");

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second transfer taken while an item is in flight");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_speed_out) &&
                                    $stable(rsp_status)))
      else $error("stalled result changed");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= ST_FULL))
      else $error("undefined status code");

   a_insert_zero_speed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_STORED || rsp_status == ST_DUP ||
                     rsp_status == ST_FULL))
      |-> (rsp_speed_out == '0))
      else $error("insert result carries a speed");

endmodule

bind spindle_speed_snap_table_core sst_checker u_sst_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_speed_out (rsp_speed_out),
   .rsp_status    (rsp_status)
);
`default_nettype wire
